// ===== hdl/mrrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrrc_pkg: shared definitions for the Modbus RTU response checker
// Frame limit, field widths, register indexes, CRC constants and status codes.
// ----------------------------------------------------------------------------
package mrrc_pkg;

	// Largest number of bytes taken into one frame; later bytes are dropped
	localparam int MAX_FRAME = 32;
	localparam int IDX_W     = $clog2(MAX_FRAME + 1);
	// Wide enough for any allowed frame limit (up to 256)
	localparam int CNT_W     = 9;

	localparam int BYTE_W    = 8;
	localparam int FUNC_W    = 7;
	localparam int STATUS_W  = 3;
	localparam int VALUE_W   = 16;
	localparam int LEN_W     = 6;
	localparam int HDR_LEN   = 5;
	localparam int MIN_LEN   = 5;

	// Result beat: status, exception code, register value, frame length
	localparam int RES_W     = STATUS_W + BYTE_W + VALUE_W + LEN_W;
	localparam int RES_TDATA_W = ((RES_W + 7) / 8) * 8;

	// CRC-16/MODBUS
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Exception flag in the function byte
	localparam logic [BYTE_W-1:0] EXC_FLAG = 8'h80;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EXP_FUNC   = 1'b1;

	// Frame check outcome
	typedef enum logic [STATUS_W-1:0] {
		ST_PASS,
		ST_EXC_PASS,
		ST_SHORT,
		ST_CRC_BAD,
		ST_SLAVE_BAD,
		ST_FUNC_BAD,
		ST_COUNT_BAD
	} status_t;

	typedef struct packed {
		logic [LEN_W-1:0]   frame_length;
		logic [VALUE_W-1:0] register_value;
		logic [BYTE_W-1:0]  exception_code;
		status_t            status;
	} result_t;

endpackage

// ===== hdl/mrrc_crc16_step.sv =====
// ----------------------------------------------------------------------------
// mrrc_crc16_step: one-byte CRC-16/MODBUS update
// Folds one byte into the running CRC, eight reflected shift steps unrolled.
// ----------------------------------------------------------------------------
module mrrc_crc16_step
	import mrrc_pkg::*;
(
	input  logic [15:0]       crc_in,
	input  logic [BYTE_W-1:0] data,
	output logic [15:0]       crc_out
);

	logic [15:0] acc;

	// Shift out one bit per step, folding in the polynomial on a set LSB
	always_comb begin
		acc = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (acc[0]) begin
				acc = (acc >> 1) ^ CRC_POLY;
			end else begin
				acc = acc >> 1;
			end
		end
		crc_out = acc;
	end

endmodule

// ===== hdl/modbus_rtu_response_checker.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker: Modbus RTU response frame validation
// Checks length, CRC-16/MODBUS, slave address, exception flag, function code
// and byte count of one received response, one byte per beat.
// ----------------------------------------------------------------------------
// The block takes one byte per clock and never stalls the input unless a
// finished result is waiting and the output side holds it off. Each byte is
// folded into the CRC once two newer bytes have arrived; the two newest are
// held back as the received CRC. A frame's result is registered and appears in
// the cycle after its tlast beat is accepted, and the next frame's first byte
// may follow in that same cycle. Up to MAX_FRAME bytes per frame are counted;
// further bytes are dropped but a tlast on one of them still closes the frame.
// The user must write slave address and expected function code through the cfg
// port only while no frame is in flight; the block itself does not enforce it.
module modbus_rtu_response_checker
	import mrrc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration writes
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [BYTE_W-1:0]      cfg_wdata,
	// Received bytes
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] rx_byte
	input  logic                   s_axis_tlast,   // frame_end
	// Check results
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [2:0] status, [10:3] exception_code, [26:11] register_value,
	// [32:27] frame_length, rest zero
	output logic [RES_TDATA_W-1:0] m_axis_tdata
);

	// Configuration
	logic [BYTE_W-1:0] slave_addr_q;
	logic [FUNC_W-1:0] exp_func_q;

	// Frame state
	logic [15:0]       crc_q;
	logic [BYTE_W-1:0] dly0_q;
	logic [BYTE_W-1:0] dly1_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BYTE_W-1:0] hdr_q [HDR_LEN];

	// Result register
	logic              m_valid_q;
	result_t           res_q;

	logic              s_fire;
	logic              take;
	logic [15:0]       crc_fed;
	logic [15:0]       nxt_crc;
	logic [BYTE_W-1:0] nxt_dly0;
	logic [BYTE_W-1:0] nxt_dly1;
	logic [IDX_W-1:0]  nxt_idx;
	logic [BYTE_W-1:0] nxt_hdr [HDR_LEN];
	logic [CNT_W-1:0]  len_ext;
	logic [15:0]       rx_crc;
	result_t           res_d;

	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = RES_TDATA_W'(res_q);

	// Bytes beyond the frame limit are dropped
	assign take = idx_q < IDX_W'(MAX_FRAME);

	mrrc_crc16_step u_crc (
		.crc_in  (crc_q),
		.data    (dly0_q),
		.crc_out (crc_fed)
	);

	// Advance the frame state by the incoming byte
	always_comb begin
		nxt_crc  = (take && idx_q >= IDX_W'(2)) ? crc_fed : crc_q;
		nxt_dly0 = take ? dly1_q : dly0_q;
		nxt_dly1 = take ? s_axis_tdata : dly1_q;
		nxt_idx  = take ? idx_q + IDX_W'(1) : idx_q;
		for (int i = 0; i < HDR_LEN; i++) begin
			nxt_hdr[i] = (take && idx_q == IDX_W'(i)) ? s_axis_tdata : hdr_q[i];
		end
	end

	// Check the frame as it stands after this byte
	always_comb begin
		len_ext = CNT_W'(nxt_idx);
		rx_crc  = {nxt_dly1, nxt_dly0};
		res_d   = '0;
		res_d.frame_length = (len_ext > CNT_W'(63)) ? LEN_W'(63) : len_ext[LEN_W-1:0];
		if (len_ext < CNT_W'(MIN_LEN)) begin
			res_d.status = ST_SHORT;
		end else if (rx_crc != nxt_crc) begin
			res_d.status = ST_CRC_BAD;
		end else if (nxt_hdr[0] != slave_addr_q) begin
			res_d.status = ST_SLAVE_BAD;
		end else if ((nxt_hdr[1] & EXC_FLAG) != '0) begin
			res_d.status         = ST_EXC_PASS;
			res_d.exception_code = nxt_hdr[2];
		end else if (nxt_hdr[1] != {1'b0, exp_func_q}) begin
			res_d.status = ST_FUNC_BAD;
		end else if (nxt_hdr[2] != BYTE_W'(len_ext - CNT_W'(MIN_LEN))) begin
			res_d.status = ST_COUNT_BAD;
		end else begin
			res_d.status         = ST_PASS;
			res_d.register_value = {nxt_hdr[3], nxt_hdr[4]};
		end
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= 8'd1;
			exp_func_q   <= 7'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLAVE_ADDR: slave_addr_q <= cfg_wdata;
				REG_EXP_FUNC:   exp_func_q   <= cfg_wdata[FUNC_W-1:0];
				default:        ;
			endcase
		end
	end

	// Advance frame state on each beat; clear it when the frame closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			dly0_q <= '0;
			dly1_q <= '0;
			idx_q  <= '0;
			for (int i = 0; i < HDR_LEN; i++) begin
				hdr_q[i] <= '0;
			end
		end else if (s_fire) begin
			if (s_axis_tlast) begin
				crc_q  <= CRC_INIT;
				dly0_q <= '0;
				dly1_q <= '0;
				idx_q  <= '0;
				for (int i = 0; i < HDR_LEN; i++) begin
					hdr_q[i] <= '0;
				end
			end else begin
				crc_q  <= nxt_crc;
				dly0_q <= nxt_dly0;
				dly1_q <= nxt_dly1;
				idx_q  <= nxt_idx;
				for (int i = 0; i < HDR_LEN; i++) begin
					hdr_q[i] <= nxt_hdr[i];
				end
			end
		end
	end

	// Load the result on a closing beat, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_fire && s_axis_tlast) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire && s_axis_tlast) begin
			res_q <= res_d;
		end
	end

	// A closing beat always produces a result next cycle
	a_close_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_axis_tlast |=> m_axis_tvalid)
		else $error("closing beat gave no result");

	// The frame restarts from an empty state after a closing beat
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_axis_tlast |=> idx_q == '0 && crc_q == CRC_INIT)
		else $error("frame state not cleared after close");

	// The byte count never passes the frame limit
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_W'(MAX_FRAME))
		else $error("byte count beyond frame limit");

	// Exception code only accompanies an exception response
	a_exc_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.status != ST_EXC_PASS |-> res_q.exception_code == '0)
		else $error("exception code on non-exception result");

	// Register value only accompanies a passing normal response
	a_value_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.status != ST_PASS |-> res_q.register_value == '0)
		else $error("register value on failing result");

endmodule
